// ===== hdl/pds_pkg.sv =====
package pds_pkg;

  localparam int MULT_MAX    = 512;
  localparam int PREDIV_MAX  = 64;
  localparam int POSTDIV_MAX = 8;
  localparam int DIV_MAX     = PREDIV_MAX * POSTDIV_MAX;

  localparam int FREQ_W    = 32;
  localparam int MULT_W    = $clog2(MULT_MAX + 2);
  localparam int PRE_W     = $clog2(PREDIV_MAX + 1);
  localparam int POST_W    = $clog2(POSTDIV_MAX + 2);
  localparam int DIV_W     = $clog2(DIV_MAX + 1);
  localparam int PROD_W    = FREQ_W + MULT_W;
  localparam int DIVCNT_W  = $clog2(PROD_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [FREQ_W-1:0] INT_OSC_RST = 32'd19200000;
  localparam logic [FREQ_W-1:0] EXT_ETH_RST = 32'd25000000;
  localparam logic [FREQ_W-1:0] EXT_TDM_RST = 32'd19200000;

  localparam logic [CFG_IDX_W-1:0] CFG_INT_OSC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_SYS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_ETH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_TDM = 2'd3;

  localparam logic [1:0] PLL_SYSTEM = 2'd0;
  localparam logic [1:0] PLL_ETH    = 2'd1;
  localparam logic [1:0] PLL_TDM    = 2'd2;
  localparam logic [1:0] PLL_UNUSED = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_SYSTEM = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  typedef enum logic [2:0] {
    DOP_START,
    DOP_DIV,
    DOP_PRE,
    DOP_REFPRE,
    DOP_MPOST,
    DOP_ACH
  } div_op_t;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_CHECK    = 17'h00002,
    S_START_W  = 17'h00004,
    S_MUL      = 17'h00008,
    S_DIV      = 17'h00010,
    S_DIV_W    = 17'h00020,
    S_POST     = 17'h00040,
    S_PRE_W    = 17'h00080,
    S_PRECHK   = 17'h00100,
    S_REFPRE_W = 17'h00200,
    S_MPOST_W  = 17'h00400,
    S_SMUL     = 17'h00800,
    S_SCORE    = 17'h01000,
    S_FIN      = 17'h02000,
    S_ACH      = 17'h04000,
    S_ACH_W    = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    div_op_t    div_op;
    logic       cap_start;
    logic       mul_ref_mult;
    logic       cap_div;
    logic       init_post;
    logic       cap_pre;
    logic       cap_refpre;
    logic       cap_mpost;
    logic       mul_score;
    logic       score;
    logic       next_post;
    logic       next_mult;
    logic       mul_final;
    logic       cap_ach;
    logic       set_status;
    logic [1:0] status;
    logic       out_load;
  } pds_cmd_t;

  typedef struct packed {
    logic pll_system;
    logic no_search;
    logic div_busy;
    logic div_done;
    logic mult_over;
    logic post_over;
    logic pre_ok;
    logic exact;
    logic found;
  } pds_stat_t;

endpackage

// ===== hdl/pds_if.sv =====
interface pds_in_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        pll_index;
  logic              use_internal_osc;
  logic [FREQ_W-1:0] target_freq;

  modport source (output valid, pll_index, use_internal_osc, target_freq, input ready);
  modport sink (input valid, pll_index, use_internal_osc, target_freq, output ready);
endinterface

interface pds_out_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [MULT_W-1:0] chosen_mult;
  logic [PRE_W-1:0]  best_prediv;
  logic [POST_W-1:0] best_postdiv;
  logic [FREQ_W-1:0] achieved_freq;
  logic [FREQ_W-1:0] freq_error;

  modport source (output valid, status, chosen_mult, best_prediv, best_postdiv,
                  achieved_freq, freq_error, input ready);
  modport sink (input valid, status, chosen_mult, best_prediv, best_postdiv,
                achieved_freq, freq_error, output ready);
endinterface

// ===== hdl/pds_div.sv =====
module pds_div import pds_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PROD_W-1:0]   dividend,
  input  logic [FREQ_W-1:0]   divisor,
  input  logic [DIVCNT_W-1:0] steps,
  output logic                busy,
  output logic                done,
  output logic [PROD_W-1:0]   quot
);

  logic [PROD_W-1:0]   q_r;
  logic [FREQ_W-1:0]   rem_r;
  logic [FREQ_W-1:0]   dsr_r;
  logic [DIVCNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [FREQ_W:0]     trial;
  logic [FREQ_W:0]     diff;
  logic                ge;
  logic [DIVCNT_W-1:0] shamt;

  assign trial = {rem_r, q_r[PROD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};
  assign shamt = DIVCNT_W'(PROD_W) - steps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend << shamt;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[PROD_W-2:0], ge};
      rem_r <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hdl/pds_dp.sv =====
module pds_dp import pds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data,
  input  logic [1:0]           pll_index,
  input  logic                 use_internal_osc,
  input  logic [FREQ_W-1:0]    target_freq,
  input  pds_cmd_t             cmd,
  output pds_stat_t            stat,
  output logic [1:0]           status,
  output logic [MULT_W-1:0]    chosen_mult,
  output logic [PRE_W-1:0]     best_prediv,
  output logic [POST_W-1:0]    best_postdiv,
  output logic [FREQ_W-1:0]    achieved_freq,
  output logic [FREQ_W-1:0]    freq_error
);

  logic [FREQ_W-1:0] int_osc_r, ext_eth_r, ext_tdm_r;
  logic [1:0]        pll_r;
  logic [FREQ_W-1:0] ref_r, target_r;
  logic [MULT_W-1:0] mult_r, mpost_r, win_mult_r;
  logic [DIV_W-1:0]  div_r;
  logic [POST_W-1:0] post_r, best_post_r;
  logic [PRE_W-1:0]  pre_r, best_pre_r;
  logic [FREQ_W-1:0] refpre_r, ach_r;
  logic [PROD_W-1:0] prod_r, best_err_r;
  logic              found_r, exact_r;
  logic [1:0]        status_r;

  logic [1:0]        out_status_r;
  logic [MULT_W-1:0] out_mult_r;
  logic [PRE_W-1:0]  out_pre_r;
  logic [POST_W-1:0] out_post_r;
  logic [FREQ_W-1:0] out_ach_r, out_err_r;

  logic [PROD_W-1:0]   dvd;
  logic [FREQ_W-1:0]   dsr;
  logic [DIVCNT_W-1:0] steps;
  logic                div_busy, div_done;
  logic [PROD_W-1:0]   quot;
  logic [PRE_W+POST_W-1:0] prepost;
  logic [PROD_W-1:0]   tgt_ext, err;
  logic                better;

  assign prepost = (PRE_W+POST_W)'(best_pre_r) * (PRE_W+POST_W)'(best_post_r);
  assign tgt_ext = PROD_W'(target_r);
  assign err     = (prod_r >= tgt_ext) ? prod_r - tgt_ext : tgt_ext - prod_r;
  assign better  = !found_r || (err < best_err_r);

  always_comb begin
    dvd   = PROD_W'(target_r);
    dsr   = ref_r;
    steps = DIVCNT_W'(FREQ_W);
    case (cmd.div_op)
      DOP_START: begin
        dvd   = PROD_W'(target_r);
        dsr   = ref_r;
        steps = DIVCNT_W'(FREQ_W);
      end
      DOP_DIV: begin
        dvd   = prod_r;
        dsr   = target_r;
        steps = DIVCNT_W'(PROD_W);
      end
      DOP_PRE: begin
        dvd   = PROD_W'(div_r);
        dsr   = FREQ_W'(post_r);
        steps = DIVCNT_W'(DIV_W);
      end
      DOP_REFPRE: begin
        dvd   = PROD_W'(ref_r);
        dsr   = FREQ_W'(pre_r);
        steps = DIVCNT_W'(FREQ_W);
      end
      DOP_MPOST: begin
        dvd   = PROD_W'(mult_r);
        dsr   = FREQ_W'(post_r);
        steps = DIVCNT_W'(MULT_W);
      end
      DOP_ACH: begin
        dvd   = prod_r;
        dsr   = FREQ_W'(prepost);
        steps = DIVCNT_W'(PROD_W);
      end
      default: begin
        dvd   = PROD_W'(target_r);
        dsr   = ref_r;
        steps = DIVCNT_W'(FREQ_W);
      end
    endcase
  end

  pds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .steps    (steps),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_osc_r <= INT_OSC_RST;
      ext_eth_r <= EXT_ETH_RST;
      ext_tdm_r <= EXT_TDM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INT_OSC: int_osc_r <= cfg_data;
        CFG_EXT_SYS: ;
        CFG_EXT_ETH: ext_eth_r <= cfg_data;
        CFG_EXT_TDM: ext_tdm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      exact_r <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      exact_r <= 1'b0;
    end else if (cmd.score && better) begin
      found_r <= 1'b1;
      exact_r <= (err == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pll_r    <= pll_index;
      target_r <= target_freq;
      if (use_internal_osc) begin
        ref_r <= int_osc_r;
      end else if (pll_index == PLL_ETH) begin
        ref_r <= ext_eth_r;
      end else begin
        ref_r <= ext_tdm_r;
      end
    end
    if (cmd.cap_start) begin
      if (quot > PROD_W'(MULT_MAX)) begin
        mult_r <= MULT_W'(MULT_MAX + 1);
      end else if (quot == '0) begin
        mult_r <= MULT_W'(1);
      end else begin
        mult_r <= quot[MULT_W-1:0];
      end
    end else if (cmd.next_mult) begin
      mult_r <= mult_r + 1'b1;
    end
    if (cmd.cap_div) begin
      div_r <= (quot > PROD_W'(DIV_MAX)) ? '0 : quot[DIV_W-1:0];
    end
    if (cmd.init_post) begin
      post_r <= POST_W'(1);
    end else if (cmd.next_post) begin
      post_r <= post_r + 1'b1;
    end
    if (cmd.cap_pre) begin
      pre_r <= (quot > PROD_W'(PREDIV_MAX)) ? '0 : quot[PRE_W-1:0];
    end
    if (cmd.cap_refpre) begin
      refpre_r <= quot[FREQ_W-1:0];
    end
    if (cmd.cap_mpost) begin
      mpost_r <= quot[MULT_W-1:0];
    end
    if (cmd.mul_ref_mult) begin
      prod_r <= PROD_W'(ref_r) * PROD_W'(mult_r);
    end else if (cmd.mul_score) begin
      prod_r <= PROD_W'(refpre_r) * PROD_W'(mpost_r);
    end else if (cmd.mul_final) begin
      prod_r <= PROD_W'(ref_r) * PROD_W'(win_mult_r);
    end
    if (cmd.score && better) begin
      best_err_r  <= err;
      win_mult_r  <= mult_r;
      best_pre_r  <= pre_r;
      best_post_r <= post_r;
    end
    if (cmd.cap_ach) begin
      ach_r <= (|quot[PROD_W-1:FREQ_W]) ? '1 : quot[FREQ_W-1:0];
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      if (status_r == ST_FOUND) begin
        out_mult_r <= win_mult_r;
        out_pre_r  <= best_pre_r;
        out_post_r <= best_post_r;
        out_ach_r  <= ach_r;
        out_err_r  <= (|best_err_r[PROD_W-1:FREQ_W]) ? '1 : best_err_r[FREQ_W-1:0];
      end else begin
        out_mult_r <= '0;
        out_pre_r  <= '0;
        out_post_r <= '0;
        out_ach_r  <= '0;
        out_err_r  <= '0;
      end
    end
  end

  assign stat.pll_system = (pll_r == PLL_SYSTEM);
  assign stat.no_search  = (pll_r == PLL_UNUSED) || (target_r == '0);
  assign stat.div_busy   = div_busy;
  assign stat.div_done   = div_done;
  assign stat.mult_over  = (mult_r > MULT_W'(MULT_MAX));
  assign stat.post_over  = (post_r > POST_W'(POSTDIV_MAX)) || (DIV_W'(post_r) > div_r);
  assign stat.pre_ok     = (pre_r != '0);
  assign stat.exact      = exact_r;
  assign stat.found      = found_r;

  assign status        = out_status_r;
  assign chosen_mult   = out_mult_r;
  assign best_prediv   = out_pre_r;
  assign best_postdiv  = out_post_r;
  assign achieved_freq = out_ach_r;
  assign freq_error    = out_err_r;

endmodule

// ===== hdl/pds_ctrl.sv =====
module pds_ctrl import pds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pds_stat_t stat,
  output pds_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pll_system) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_SYSTEM;
          state_nxt      = S_DONE;
        end else if (stat.no_search) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DOP_START;
          state_nxt     = S_START_W;
        end
      end
      S_START_W: begin
        if (stat.div_done) begin
          cmd.cap_start = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.mult_over || stat.exact) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_ref_mult = 1'b1;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_DIV;
        state_nxt     = S_DIV_W;
      end
      S_DIV_W: begin
        if (stat.div_done) begin
          cmd.cap_div   = 1'b1;
          cmd.init_post = 1'b1;
          state_nxt     = S_POST;
        end
      end
      S_POST: begin
        if (stat.exact) begin
          state_nxt = S_FIN;
        end else if (stat.post_over) begin
          cmd.next_mult = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DOP_PRE;
          state_nxt     = S_PRE_W;
        end
      end
      S_PRE_W: begin
        if (stat.div_done) begin
          cmd.cap_pre = 1'b1;
          state_nxt   = S_PRECHK;
        end
      end
      S_PRECHK: begin
        if (!stat.pre_ok) begin
          cmd.next_post = 1'b1;
          state_nxt     = S_POST;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DOP_REFPRE;
          state_nxt     = S_REFPRE_W;
        end
      end
      S_REFPRE_W: begin
        if (stat.div_done) begin
          cmd.cap_refpre = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_op     = DOP_MPOST;
          state_nxt      = S_MPOST_W;
        end
      end
      S_MPOST_W: begin
        if (stat.div_done) begin
          cmd.cap_mpost = 1'b1;
          state_nxt     = S_SMUL;
        end
      end
      S_SMUL: begin
        cmd.mul_score = 1'b1;
        state_nxt     = S_SCORE;
      end
      S_SCORE: begin
        cmd.score     = 1'b1;
        cmd.next_post = 1'b1;
        state_nxt     = S_POST;
      end
      S_FIN: begin
        if (!stat.found) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          cmd.mul_final = 1'b1;
          state_nxt     = S_ACH;
        end
      end
      S_ACH: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_ACH;
        state_nxt     = S_ACH_W;
      end
      S_ACH_W: begin
        if (stat.div_done) begin
          cmd.cap_ach    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_FOUND;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (!stat.div_busy || stat.div_done))
    else $error("Divider started while busy.");

  a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("Result loaded without raising valid.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Second request taken while one is in work.");

endmodule

// ===== hdl/pll_divider_search_top.sv =====
// The block takes one request word on in_ch (PLL index, reference source,
// target frequency) and returns one result word on out_ch with the status,
// the chosen multiplier, pre-divider and post-divider, the achieved frequency
// and the frequency error.
// The user writes reference frequencies through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce it.
// One request is worked on at a time. A refused or empty request is
// answered without a search. A search tries multipliers in turn and scores
// the post-dividers for each one, and every quotient goes through one shared
// radix-2 divider one bit per cycle.
// The result sits in an output register; the next request is taken as soon
// as that register is loaded, and a stalled receiver only holds a finished
// result from leaving its final state.
// Reset restores the default reference frequencies and empties the block.
module pll_divider_search_top import pds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data,
  pds_in_if.sink               in_ch,
  pds_out_if.source            out_ch
);

  pds_cmd_t  cmd;
  pds_stat_t stat;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pds_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pll_index        (in_ch.pll_index),
    .use_internal_osc (in_ch.use_internal_osc),
    .target_freq      (in_ch.target_freq),
    .cmd              (cmd),
    .stat             (stat),
    .status           (out_ch.status),
    .chosen_mult      (out_ch.chosen_mult),
    .best_prediv      (out_ch.best_prediv),
    .best_postdiv     (out_ch.best_postdiv),
    .achieved_freq    (out_ch.achieved_freq),
    .freq_error       (out_ch.freq_error)
  );

endmodule
